// File: sv/assert_macros.svh
// assertion macros shared by the ir remote decoder rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define IRPFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define IRPFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/irpfd_pkg.sv
// types, codes and constants of the ir remote pulse frame decoder
// no dependencies
package irpfd_pkg;

  localparam int unsigned MAX_BITS   = 64;
  localparam int unsigned KEY_SLOTS  = 8;
  localparam int unsigned STORE_W    = 64;
  localparam int unsigned HELD_W     = 7;
  localparam int unsigned BIT_IDX_W  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // event kinds
  localparam logic EVT_EDGE    = 1'b0;
  localparam logic EVT_TIMEOUT = 1'b1;

  // frame kinds
  localparam logic [1:0] FRAME_NEW     = 2'd0;
  localparam logic [1:0] FRAME_REPEAT  = 2'd1;
  localparam logic [1:0] FRAME_UNKNOWN = 2'd2;

  localparam logic [7:0] REPEAT_BYTE = 8'h07;
  localparam logic [3:0] NEW_BYTES   = 4'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_PREFIX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_FIRST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_SECOND   = 3'd5;

  localparam logic [31:0] RST_BIT_THRESHOLD = 32'd1500000;
  localparam logic [6:0]  RST_MIN_BITS      = 7'd3;
  localparam logic [15:0] RST_MAGIC_PREFIX  = 16'hB0B3;

  typedef struct packed {
    logic        event_kind;
    logic [31:0] edge_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [15:0] keycode;
    logic [3:0]  byte_count;
    logic        key_matched;
    logic [2:0]  key_slot;
  } out_t;

  typedef struct packed {
    logic [31:0] bit_threshold;
    logic [6:0]  min_bits;
    logic [15:0] magic_prefix;
    logic [3:0]  key_count;
    logic [63:0] keys_first_half;
    logic [63:0] keys_second_half;
  } cfg_t;

endpackage

// File: sv/ir_remote_pulse_frame_decoder_core.sv
// top level of the ir remote pulse frame decoder
// depends on irpfd_pkg, irpfd_frame_decode and assert_macros.svh
//
// usage:
//   in channel  (in_valid_i, in_data_i, in_stall_o): one event per transfer,
//   either an edge with its timestamp or a silence timeout.
//   out channel (out_valid_o, out_data_o, out_stall_i): one decoded frame per
//   transfer, given when the bit store fills or a timeout finds at least
//   min_bits bits held; other events give no transfer.
//   cfg port (cfg_we_i, cfg_idx_i, cfg_wdata_i): register writes, only while
//   the block is idle.
//   path: a taken event is held in the input register and decoded from there,
//   and its frame is registered in the result register behind out_valid_o.
//   throughput: one event per cycle while the out channel does not stall; the input
//   register, the decode logic and the result register form a two-stage path with no iteration.
//   stall: while the result register holds an untaken frame, the input
//   register waits and in_stall_o rises once it is also full.
//   reset: clears the edge stamp, bit store, held count, last keycode and the
//   valid flags, and loads the register defaults.
`include "assert_macros.svh"

module ir_remote_pulse_frame_decoder_core import irpfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  in_t                   in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output out_t                  out_data_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               in_valid_q;
  in_t                in_q;
  logic               out_valid_q;
  out_t               out_q;
  logic [31:0]        stamp_q, stamp_d;
  logic [STORE_W-1:0] store_q, store_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [15:0]        prev_q, prev_d;

  logic               adv, fire, in_take;
  logic               is_edge;
  logic [31:0]        gap;
  logic               new_bit;
  logic [STORE_W-1:0] edge_store;
  logic [STORE_W-1:0] dec_store;
  logic [HELD_W-1:0]  dec_held;
  logic               res_valid;
  out_t               res;
  logic               new_key;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold    <= RST_BIT_THRESHOLD;
      cfg_q.min_bits         <= RST_MIN_BITS;
      cfg_q.magic_prefix     <= RST_MAGIC_PREFIX;
      cfg_q.key_count        <= '0;
      cfg_q.keys_first_half  <= '0;
      cfg_q.keys_second_half <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_THRESHOLD: cfg_q.bit_threshold    <= cfg_wdata_i[31:0];
        CFG_MIN_BITS:      cfg_q.min_bits         <= cfg_wdata_i[6:0];
        CFG_MAGIC_PREFIX:  cfg_q.magic_prefix     <= cfg_wdata_i[15:0];
        CFG_KEY_COUNT:     cfg_q.key_count        <= cfg_wdata_i[3:0];
        CFG_KEYS_FIRST:    cfg_q.keys_first_half  <= cfg_wdata_i;
        CFG_KEYS_SECOND:   cfg_q.keys_second_half <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // bit forming
  assign is_edge    = (in_q.event_kind == EVT_EDGE);
  assign gap        = in_q.edge_time - stamp_q;
  assign new_bit    = gap > cfg_q.bit_threshold;
  assign edge_store = store_q | (STORE_W'(new_bit) << held_q[BIT_IDX_W-1:0]);
  assign dec_store  = is_edge ? edge_store : store_q;
  assign dec_held   = is_edge ? HELD_W'(MAX_BITS) : held_q;

  always_comb begin
    if (is_edge) begin
      res_valid = (held_q == HELD_W'(MAX_BITS - 1));
    end else begin
      res_valid = (held_q >= cfg_q.min_bits);
    end
  end

  irpfd_frame_decode u_decode (
    .store_i    (dec_store),
    .held_i     (dec_held),
    .prev_key_i (prev_q),
    .cfg_i      (cfg_q),
    .result_o   (res),
    .new_key_o  (new_key)
  );

  // state update
  always_comb begin
    stamp_d = stamp_q;
    store_d = store_q;
    held_d  = held_q;
    prev_d  = prev_q;
    if (fire) begin
      if (is_edge) begin
        stamp_d = in_q.edge_time;
        store_d = edge_store;
        held_d  = held_q + HELD_W'(1);
      end
      if (res_valid) begin
        store_d = '0;
        held_d  = '0;
        if (new_key) begin
          prev_d = res.keycode;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      store_q <= '0;
      held_q  <= '0;
      prev_q  <= '0;
    end else begin
      stamp_q <= stamp_d;
      store_q <= store_d;
      held_q  <= held_d;
      prev_q  <= prev_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IRPFD_ASSERT_NEXT(a_clear_after_decode, fire && res_valid, held_q == '0 && store_q == '0,
    "bit store not cleared after a decoded frame")
  `IRPFD_ASSERT_NEXT(a_held_counts_edges, fire && is_edge && !res_valid,
    held_q == $past(held_q) + HELD_W'(1), "held bit count did not advance on an edge")
  `IRPFD_ASSERT_NEXT(a_prev_tracks_new, fire && res_valid && new_key,
    prev_q == out_q.keycode, "last keycode not taken from a new frame")
  `IRPFD_ASSERT_NOW(a_unknown_is_empty, out_valid_q && out_q.frame_kind == FRAME_UNKNOWN,
    out_q.keycode == '0 && !out_q.key_matched && out_q.key_slot == '0,
    "unknown frame carries key data")

endmodule

// File: sv/irpfd_frame_decode.sv
// frame classification and key table lookup for the ir remote decoder
// depends on irpfd_pkg
module irpfd_frame_decode import irpfd_pkg::*; (
  input  logic [STORE_W-1:0] store_i,
  input  logic [HELD_W-1:0]  held_i,
  input  logic [15:0]        prev_key_i,
  input  cfg_t               cfg_i,
  output out_t               result_o,
  output logic               new_key_o
);

  logic [7:0]               byte0, byte1;
  logic [3:0]               nbytes;
  logic [HELD_W-1:0]        held_m1;
  logic [1:0]               kind;
  logic [15:0]              code;
  logic [3:0]               limit;
  logic [16*KEY_SLOTS-1:0]  table_bits;
  logic                     matched;
  logic [2:0]               slot;

  assign byte0      = store_i[7:0];
  assign byte1      = store_i[15:8];
  assign held_m1    = held_i - HELD_W'(1);
  assign table_bits = {cfg_i.keys_second_half, cfg_i.keys_first_half};
  assign limit      = (cfg_i.key_count > 4'(KEY_SLOTS)) ? 4'(KEY_SLOTS) : cfg_i.key_count;

  always_comb begin
    if (held_i == '0) begin
      nbytes = 4'd1;
    end else begin
      nbytes = 4'(held_m1 >> 3) + 4'd1;
    end
  end

  always_comb begin
    kind = FRAME_UNKNOWN;
    code = '0;
    if (nbytes == NEW_BYTES && byte0 == cfg_i.magic_prefix[7:0] &&
        byte1 == cfg_i.magic_prefix[15:8]) begin
      kind = FRAME_NEW;
      code = store_i[31:16];
    end else if (nbytes == 4'd1 && byte0 == REPEAT_BYTE && prev_key_i != '0) begin
      kind = FRAME_REPEAT;
      code = prev_key_i;
    end
  end

  // lowest matching slot wins
  always_comb begin
    matched = 1'b0;
    slot    = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (4'(i) < limit && table_bits[16*i +: 16] == code && kind != FRAME_UNKNOWN) begin
        matched = 1'b1;
        slot    = 3'(i);
      end
    end
  end

  always_comb begin
    result_o.frame_kind  = kind;
    result_o.keycode     = code;
    result_o.byte_count  = nbytes;
    result_o.key_matched = matched;
    result_o.key_slot    = slot;
  end

  assign new_key_o = (kind == FRAME_NEW);

endmodule

// File: tb/sv/ir_remote_pulse_frame_decoder_core_tb.sv
// self-checking testbench of ir_remote_pulse_frame_decoder_core: edge and timeout events in,
// decoded frames out, each frame checked against a frame predictor kept in a scoreboard class
// depends on irpfd_pkg and the decoder rtl
`timescale 1ns / 100ps

module ir_remote_pulse_frame_decoder_core_tb;
  import irpfd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 165;

  class frame_board;
    logic [31:0] thr;
    logic [6:0]  min_bits;
    logic [15:0] magic;
    logic [3:0]  key_cnt;
    logic [63:0] keys_lo;
    logic [63:0] keys_hi;
    logic [31:0] last_stamp;
    logic [63:0] store;
    logic [6:0]  held;
    logic [15:0] prev_code;
    out_t        frames_due[$];
    int          errors;

    function new();
      thr        = RST_BIT_THRESHOLD;
      min_bits   = RST_MIN_BITS;
      magic      = RST_MAGIC_PREFIX;
      key_cnt    = '0;
      keys_lo    = '0;
      keys_hi    = '0;
      last_stamp = '0;
      store      = '0;
      held       = '0;
      prev_code  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_BIT_THRESHOLD: thr = v[31:0];
        CFG_MIN_BITS:      min_bits = v[6:0];
        CFG_MAGIC_PREFIX:  magic = v[15:0];
        CFG_KEY_COUNT:     key_cnt = v[3:0];
        CFG_KEYS_FIRST:    keys_lo = v;
        CFG_KEYS_SECOND:   keys_hi = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] slot_key(int s);
      if (s < 4) return keys_lo[16*s +: 16];
      return keys_hi[16*(s-4) +: 16];
    endfunction

    function void decode_held();
      out_t f;
      int   nbytes;
      int   lim;
      nbytes = (held == 0) ? 1 : (int'(held) - 1) / 8 + 1;
      f = '0;
      f.frame_kind = FRAME_UNKNOWN;
      f.byte_count = nbytes[3:0];
      if (nbytes == int'(NEW_BYTES) && store[7:0] == magic[7:0] &&
          store[15:8] == magic[15:8]) begin
        f.frame_kind = FRAME_NEW;
        f.keycode = store[31:16];
        prev_code = store[31:16];
      end else if (nbytes == 1 && store[7:0] == REPEAT_BYTE && prev_code != 0) begin
        f.frame_kind = FRAME_REPEAT;
        f.keycode = prev_code;
      end
      if (f.frame_kind != FRAME_UNKNOWN) begin
        lim = (key_cnt > KEY_SLOTS) ? KEY_SLOTS : int'(key_cnt);
        for (int i = 0; i < lim; i++) begin
          if (!f.key_matched && slot_key(i) == f.keycode) begin
            f.key_matched = 1'b1;
            f.key_slot = i[2:0];
          end
        end
      end
      frames_due.push_back(f);
      store = '0;
      held = '0;
    endfunction

    function void note_event(in_t ev);
      logic [31:0] gap;
      if (ev.event_kind == EVT_EDGE) begin
        gap = ev.edge_time - last_stamp;
        last_stamp = ev.edge_time;
        if (gap > thr) store[held[5:0]] = 1'b1;
        held++;
        if (held >= MAX_BITS) decode_held();
      end else if (held >= min_bits) begin
        decode_held();
      end
    endfunction

    function void check_frame(out_t got);
      out_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: frame with no expectation, actual %h", $time, got);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (got.frame_kind != want.frame_kind) begin
        $display("%0t: frame_kind expected %0d actual %0d", $time, want.frame_kind,
                 got.frame_kind);
        errors++;
      end
      if (got.keycode != want.keycode) begin
        $display("%0t: keycode expected %h actual %h", $time, want.keycode, got.keycode);
        errors++;
      end
      if (got.byte_count != want.byte_count) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                 got.byte_count);
        errors++;
      end
      if (got.key_matched != want.key_matched) begin
        $display("%0t: key_matched expected %0d actual %0d", $time, want.key_matched,
                 got.key_matched);
        errors++;
      end
      if (got.key_slot != want.key_slot) begin
        $display("%0t: key_slot expected %0d actual %0d", $time, want.key_slot, got.key_slot);
        errors++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  in_t                   in_data;
  logic                  in_stall;
  logic                  out_valid;
  out_t                  out_data;
  logic                  out_stall;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frame_board  board;
  bit          quiet;
  logic [31:0] stamp_now;
  int          sent;
  int unsigned idle_cycles;

  ir_remote_pulse_frame_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_frame(out_data);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("ir_remote_pulse_frame_decoder_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall before each frame transfer
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 14);
      @(negedge clk_i);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic send_item(in_t ev);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk_i); while (in_stall);
    board.note_event(ev);
    sent++;
  endtask

  task automatic send_edge_at(logic [31:0] t);
    in_t ev;
    stamp_now = t;
    ev.event_kind = EVT_EDGE;
    ev.edge_time = t;
    send_item(ev);
  endtask

  task automatic send_bit(bit b);
    logic [31:0] gap;
    logic [31:0] room;
    logic [31:0] thr;
    thr = board.thr;
    if (b && thr != 32'hFFFF_FFFF) begin
      room = 32'hFFFF_FFFF - thr - 32'd1;
      gap = thr + 32'd1 +
            (($urandom_range(0, 3) == 0) ? 32'd0 :
             $urandom_range(0, (room > 32'd50000) ? 32'd50000 : room));
    end else if (b) begin
      gap = $urandom;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? thr : $urandom_range(0, thr);
    end
    send_edge_at(stamp_now + gap);
  endtask

  task automatic send_timeout();
    in_t ev;
    ev.event_kind = EVT_TIMEOUT;
    ev.edge_time = $urandom;
    send_item(ev);
  endtask

  task automatic send_bits(logic [63:0] bits, int n);
    for (int i = 0; i < n; i++) send_bit(bits[i]);
  endtask

  task automatic key_frame(bit broken);
    logic [15:0] code;
    logic [63:0] bits;
    int          n;
    code = ($urandom_range(0, 2) != 0) ? board.slot_key($urandom_range(0, 7)) : 16'($urandom);
    bits = {24'($urandom), ~code[7:0], code, board.magic};
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 39) : 40;
    if (broken) begin
      case ($urandom_range(0, 2))
        0: bits[$urandom_range(0, 15)] ^= 1'b1;
        1: n = $urandom_range(41, 48);
        default: n = $urandom_range(25, 32);
      endcase
    end
    send_bits(bits, n);
    send_timeout();
  endtask

  task automatic repeat_frame();
    logic [63:0] bits;
    bits = 64'(REPEAT_BYTE);
    if ($urandom_range(0, 5) == 0) bits[$urandom_range(0, 7)] ^= 1'b1;
    send_bits(bits, $urandom_range(3, 8));
    send_timeout();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) send_timeout();
      else send_edge_at($urandom);
    end
  endtask

  // wait until every frame has been taken and the pipeline is empty
  task automatic settle_block();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [31:0] thr, logic [6:0] minb, logic [15:0] magic,
                               logic [3:0] kc, logic [63:0] klo, logic [63:0] khi);
    settle_block();
    write_reg(CFG_BIT_THRESHOLD, 64'(thr));
    write_reg(CFG_MIN_BITS, 64'(minb));
    write_reg(CFG_MAGIC_PREFIX, 64'(magic));
    write_reg(CFG_KEY_COUNT, 64'(kc));
    write_reg(CFG_KEYS_FIRST, klo);
    write_reg(CFG_KEYS_SECOND, khi);
  endtask

  task automatic make_keys(output logic [63:0] klo, output logic [63:0] khi);
    logic [15:0] k[8];
    for (int i = 0; i < 8; i++) k[i] = $urandom;
    k[$urandom_range(4, 7)] = k[$urandom_range(0, 3)];
    if ($urandom_range(0, 1) == 0) k[$urandom_range(0, 7)] = 16'h0000;
    if ($urandom_range(0, 1) == 0) k[$urandom_range(0, 7)] = 16'hFFFF;
    klo = {k[3], k[2], k[1], k[0]};
    khi = {k[7], k[6], k[5], k[4]};
  endtask

  task automatic run_phase(int budget);
    int  pick;
    bit  paused;
    sent = 0;
    paused = 0;
    while (sent < budget) begin
      if (!paused && sent >= budget / 2) begin
        settle_block();
        paused = 1;
      end
      quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) key_frame(0);
      else if (pick < 55) key_frame(1);
      else if (pick < 72) repeat_frame();
      else if (pick < 85) begin
        send_bits({$urandom, $urandom}, $urandom_range(0, 63));
        send_timeout();
      end else if (pick < 93) noise_burst();
      else begin
        send_bits({$urandom, $urandom}, 64);
        if ($urandom_range(0, 1) == 0) send_timeout();
      end
    end
  endtask

  initial begin
    logic [63:0] klo;
    logic [63:0] khi;
    board       = new();
    quiet       = 1'b0;
    stamp_now   = '0;
    sent        = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: timeout with nothing held, first edge from zero, gap equal to
    // the threshold, short timeout keeping bits, wrapping gap, repeat with no keycode
    send_timeout();
    send_edge_at(32'd1500001);
    send_edge_at(32'd3000001);
    send_timeout();
    send_edge_at(32'd3000000);
    send_timeout();
    send_bits(64'h7, 3);
    send_timeout();
    key_frame(0);
    repeat_frame();

    for (int p = 0; p < 5; p++) begin
      make_keys(klo, khi);
      case (p)
        0: apply_setting(RST_BIT_THRESHOLD, RST_MIN_BITS, RST_MAGIC_PREFIX, 4'd8, klo, khi);
        1: apply_setting(32'd0, 7'd0, 16'hFFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, khi);
        2: apply_setting(32'hFFFF_FFFF, 7'd64, 16'h0000, 4'd0, klo, khi);
        3: apply_setting($urandom_range(1000, 100000), 7'($urandom_range(1, 40)),
                         16'($urandom), 4'($urandom_range(1, 7)), klo, khi);
        default: apply_setting($urandom, 7'($urandom_range(0, 64)), 16'($urandom),
                               4'($urandom_range(0, 15)), klo, khi);
      endcase
      run_phase(PHASE_ITEMS);
    end

    settle_block();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ir_remote_pulse_frame_decoder_core: match");
    end else begin
      $display("ir_remote_pulse_frame_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
